### hw/rtl/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants for the line and rectangle rasterizer.
// ----------------------------------------------------------------------------
package lrr_pkg;

  // Internal coordinate width; corners and the walk wrap modulo 2^COORD_BITS
  localparam int COORD_BITS = 10;
  localparam int ACC_BITS   = COORD_BITS + 1;
  // Fixed widths of the port fields
  localparam int PIX_BITS   = 10;
  localparam int COLOR_BITS = 16;
  localparam int OP_BITS    = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_BITS-1:0]   acc_t;
  typedef logic [PIX_BITS-1:0]   pix_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_LINE = 2'd0,
    OP_RECT = 2'd1,
    OP_STEP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

  localparam logic [1:0] SEG_LAST = 2'd3;

  // One accepted command word
  typedef struct packed {
    logic [OP_BITS-1:0] opcode;
    pix_t               x_start;
    pix_t               y_start;
    pix_t               x_end;
    pix_t               y_end;
    color_t             ink_color;
  } item_t;

  // One emitted pixel
  typedef struct packed {
    logic   valid;
    pix_t   x;
    pix_t   y;
    color_t color;
    logic   done;
  } pixel_t;

  // Engine status for checking
  typedef struct packed {
    logic   busy;
    acc_t   steps_done;
    coord_t span;
  } eng_stat_t;

endpackage

### hw/rtl/lrr_engine.sv
// ----------------------------------------------------------------------------
// lrr_engine
// Shape state and one-word DDA step: loads lines and rectangle edges, and
// produces the pixel for each step word while a shape is active.
// ----------------------------------------------------------------------------
module lrr_engine import lrr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  item_t     item,
  output pixel_t    res,
  output eng_stat_t stat
);

  typedef struct packed {
    coord_t mag;
    dir_t   dir;
  } axis_t;

  function automatic axis_t axis_setup(coord_t a, coord_t b);
    axis_t r;
    if (b > a) begin
      r.mag = b - a;
      r.dir = DIR_PLUS;
    end else if (b == a) begin
      r.mag = '0;
      r.dir = DIR_NONE;
    end else begin
      r.mag = a - b;
      r.dir = DIR_MINUS;
    end
    return r;
  endfunction

  function automatic coord_t move_axis(coord_t pos, dir_t dir);
    coord_t r;
    case (dir)
      DIR_PLUS:  r = pos + coord_t'(1);
      DIR_MINUS: r = pos - coord_t'(1);
      default:   r = pos;
    endcase
    return r;
  endfunction

  // State registers
  logic       busy, busy_next;
  logic       rect_mode, rect_mode_next;
  logic [1:0] segment, segment_next;
  coord_t     corner_xa, corner_xa_next, corner_ya, corner_ya_next;
  coord_t     corner_xb, corner_xb_next, corner_yb, corner_yb_next;
  coord_t     cur_col, cur_col_next, cur_row, cur_row_next;
  coord_t     abs_dx, abs_dx_next, abs_dy, abs_dy_next;
  dir_t       dir_col, dir_col_next, dir_row, dir_row_next;
  coord_t     span, span_next;
  acc_t       acc_col, acc_col_next, acc_row, acc_row_next;
  acc_t       steps_done, steps_done_next;
  color_t     ink, ink_next;

  // Segment loader inputs
  logic       is_start;
  coord_t     src_xa, src_ya, src_xb, src_yb;
  logic [1:0] ld_seg;
  coord_t     ld_x0, ld_y0, ld_x1, ld_y1;
  axis_t      ld_ax, ld_ay;
  coord_t     ld_span;

  // Step arithmetic
  acc_t       steps_inc, acc_col_sum, acc_row_sum, span_ext;

  assign is_start = (item.opcode == OP_LINE) || (item.opcode == OP_RECT);

  // Pick the corners and the segment to load
  always_comb begin
    if (is_start) begin
      src_xa = COORD_BITS'(item.x_start);
      src_ya = COORD_BITS'(item.y_start);
      src_xb = COORD_BITS'(item.x_end);
      src_yb = COORD_BITS'(item.y_end);
      ld_seg = 2'd0;
    end else begin
      src_xa = corner_xa;
      src_ya = corner_ya;
      src_xb = corner_xb;
      src_yb = corner_yb;
      ld_seg = segment + 2'd1;
    end
  end

  // Endpoints of the segment: top, left, bottom, right edge
  always_comb begin
    case (ld_seg)
      2'd0: begin
        ld_x0 = src_xa; ld_y0 = src_ya; ld_x1 = src_xb; ld_y1 = src_ya;
      end
      2'd1: begin
        ld_x0 = src_xa; ld_y0 = src_ya; ld_x1 = src_xa; ld_y1 = src_yb;
      end
      2'd2: begin
        ld_x0 = src_xa; ld_y0 = src_yb; ld_x1 = src_xb; ld_y1 = src_yb;
      end
      default: begin
        ld_x0 = src_xb; ld_y0 = src_ya; ld_x1 = src_xb; ld_y1 = src_yb;
      end
    endcase
    ld_ax   = axis_setup(ld_x0, ld_x1);
    ld_ay   = axis_setup(ld_y0, ld_y1);
    ld_span = (ld_ax.mag > ld_ay.mag) ? ld_ax.mag : ld_ay.mag;
  end

  assign span_ext    = {1'b0, span};
  assign steps_inc   = steps_done + acc_t'(1);
  assign acc_col_sum = acc_col + {1'b0, abs_dx};
  assign acc_row_sum = acc_row + {1'b0, abs_dy};

  // Next state and pixel for the word in hand
  always_comb begin
    busy_next       = busy;
    rect_mode_next  = rect_mode;
    segment_next    = segment;
    corner_xa_next  = corner_xa;
    corner_ya_next  = corner_ya;
    corner_xb_next  = corner_xb;
    corner_yb_next  = corner_yb;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    abs_dx_next     = abs_dx;
    abs_dy_next     = abs_dy;
    dir_col_next    = dir_col;
    dir_row_next    = dir_row;
    span_next       = span;
    acc_col_next    = acc_col;
    acc_row_next    = acc_row;
    steps_done_next = steps_done;
    ink_next        = ink;
    res             = '0;

    if (fire) begin
      case (item.opcode)
        OP_LINE, OP_RECT: begin
          corner_xa_next = src_xa;
          corner_ya_next = src_ya;
          corner_xb_next = src_xb;
          corner_yb_next = src_yb;
          ink_next       = item.ink_color;
          rect_mode_next = (item.opcode == OP_RECT);
          segment_next   = 2'd0;
          busy_next      = 1'b1;
        end
        OP_STEP: begin
          if (busy) begin
            res.valid       = 1'b1;
            res.x           = PIX_BITS'(cur_col);
            res.y           = PIX_BITS'(cur_row);
            res.color       = ink;
            steps_done_next = steps_inc;
            if (steps_inc > span_ext) begin
              if (rect_mode && (segment != SEG_LAST)) begin
                segment_next = ld_seg;
              end else begin
                busy_next = 1'b0;
                res.done  = 1'b1;
              end
            end else begin
              // Advance each axis when its error passes the span
              acc_col_next = acc_col_sum;
              acc_row_next = acc_row_sum;
              if (acc_col_sum > span_ext) begin
                acc_col_next = acc_col_sum - span_ext;
                cur_col_next = move_axis(cur_col, dir_col);
              end
              if (acc_row_sum > span_ext) begin
                acc_row_next = acc_row_sum - span_ext;
                cur_row_next = move_axis(cur_row, dir_row);
              end
            end
          end
        end
        default: ;
      endcase

      // Load a fresh segment on start or on moving to the next edge
      if (is_start || (segment_next != segment)) begin
        cur_col_next    = ld_x0;
        cur_row_next    = ld_y0;
        abs_dx_next     = ld_ax.mag;
        abs_dy_next     = ld_ay.mag;
        dir_col_next    = ld_ax.dir;
        dir_row_next    = ld_ay.dir;
        span_next       = ld_span;
        acc_col_next    = '0;
        acc_row_next    = '0;
        steps_done_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      rect_mode  <= 1'b0;
      segment    <= 2'd0;
      corner_xa  <= '0;
      corner_ya  <= '0;
      corner_xb  <= '0;
      corner_yb  <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      abs_dx     <= '0;
      abs_dy     <= '0;
      dir_col    <= DIR_NONE;
      dir_row    <= DIR_NONE;
      span       <= '0;
      acc_col    <= '0;
      acc_row    <= '0;
      steps_done <= '0;
      ink        <= '0;
    end else begin
      busy       <= busy_next;
      rect_mode  <= rect_mode_next;
      segment    <= segment_next;
      corner_xa  <= corner_xa_next;
      corner_ya  <= corner_ya_next;
      corner_xb  <= corner_xb_next;
      corner_yb  <= corner_yb_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      abs_dx     <= abs_dx_next;
      abs_dy     <= abs_dy_next;
      dir_col    <= dir_col_next;
      dir_row    <= dir_row_next;
      span       <= span_next;
      acc_col    <= acc_col_next;
      acc_row    <= acc_row_next;
      steps_done <= steps_done_next;
      ink        <= ink_next;
    end
  end

  assign stat.busy       = busy;
  assign stat.steps_done = steps_done;
  assign stat.span       = span;

endmodule

### hw/rtl/line_rectangle_rasterizer_unit.sv
// Path: a word reaches the input register on acceptance; the pixel of a
//   step word goes through the engine into the result register, where
//   out_valid rises and the pixel is held until out_ready takes it.
// Throughput: one word per cycle while the result register is free or
//   being drained; one pixel per step word while a shape is active.
// Reset: synchronous, active high; clears the handshake valids and all shape
//   state, leaving the rasterizer idle.
// ----------------------------------------------------------------------------
// line_rectangle_rasterizer_unit
// Line and rectangle outline pixel generator with registered input and
// result stages.
// ----------------------------------------------------------------------------
module line_rectangle_rasterizer_unit import lrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_BITS-1:0]    opcode,
  input  logic [PIX_BITS-1:0]   x_start,
  input  logic [PIX_BITS-1:0]   y_start,
  input  logic [PIX_BITS-1:0]   x_end,
  input  logic [PIX_BITS-1:0]   y_end,
  input  logic [COLOR_BITS-1:0] ink_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_BITS-1:0]   pixel_x,
  output logic [PIX_BITS-1:0]   pixel_y,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  shape_done
);

  logic      s1_valid;
  item_t     s1_item;
  logic      out_free;
  logic      adv;
  logic      in_fire;
  pixel_t    eng_res;
  eng_stat_t eng_stat;

  // Stage moves when the result slot is empty or being drained
  assign out_free = !out_valid || out_ready;
  assign adv      = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.opcode    <= opcode;
      s1_item.x_start   <= x_start;
      s1_item.y_start   <= y_start;
      s1_item.x_end     <= x_end;
      s1_item.y_end     <= y_end;
      s1_item.ink_color <= ink_color;
    end
  end

  lrr_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (s1_item),
    .res  (eng_res),
    .stat (eng_stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv && eng_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && eng_res.valid) begin
      pixel_x     <= eng_res.x;
      pixel_y     <= eng_res.y;
      pixel_color <= eng_res.color;
      shape_done  <= eng_res.done;
    end
  end

`ifndef SYNTH
  // Only a step word can produce a pixel
  a_pix_from_step: assert property (@(posedge clk) disable iff (rst)
    (adv && eng_res.valid) |-> (s1_item.opcode == OP_STEP))
    else $error("pixel produced by a non-step word");

  // A start word always leaves the engine busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_item.opcode == OP_LINE || s1_item.opcode == OP_RECT))
      |=> eng_stat.busy)
    else $error("engine idle after start");

  // The final pixel of a shape returns the engine to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && eng_res.valid && eng_res.done) |=> !eng_stat.busy)
    else $error("engine still busy after final pixel");

  // While a segment is active its step count never passes the span
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    eng_stat.busy |-> (eng_stat.steps_done <= {1'b0, eng_stat.span}))
    else $error("step count beyond span");
`endif

endmodule
